FILE: rtl/chbd_pkg.sv
// Shared types, character codes and the hex digit decoder of the chunked body decoder.
package chbd_pkg;

   localparam int SIZE_BITS_DEFAULT = 32;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;

   typedef enum logic [3:0] {
      PH_LEAD    = 4'd0,
      PH_DIGITS  = 4'd1,
      PH_EXT     = 4'd2,
      PH_DATA    = 4'd3,
      PH_DATA_CR = 4'd4,
      PH_DATA_LF = 4'd5,
      PH_TRAILER = 4'd6,
      PH_DONE    = 4'd7,
      PH_ERROR   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_NO_HEX   = 2'd1,
      ERR_CRLF     = 2'd2,
      ERR_OVERFLOW = 2'd3
   } err_type;

   // Narrow decoder control state.
   typedef struct packed {
      phase_type phase;
      logic      saw_hex;
      logic      prev_cr;
      logic      line_ne;
   } ctrl_type;

   localparam ctrl_type CTRL_RESET = '{phase: PH_LEAD, saw_hex: 1'b0,
                                       prev_cr: 1'b0, line_ne: 1'b0};

   // One result item.
   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       body_done;
      logic       error_flag;
      err_type    error_code;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         h.value = 4'(c - 8'h30);
      end else if (c inside {[8'h61:8'h66]}) begin
         h.value = 4'(c - 8'h57);
      end else if (c inside {[8'h41:8'h46]}) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

FILE: rtl/chbd_step.sv
// Per-byte next-state and result logic of the chunked body decoder.
module chbd_step
   import chbd_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  logic [7:0]           data_byte,
   input  logic                 body_start,
   input  ctrl_type             ctrl_cur,
   input  logic [SIZE_BITS-1:0] chunk_cur,
   input  logic [SIZE_BITS-1:0] left_cur,
   output ctrl_type             ctrl_nxt,
   output logic [SIZE_BITS-1:0] chunk_nxt,
   output logic [SIZE_BITS-1:0] left_nxt,
   output result_type           result
);

   ctrl_type             ctrl;
   logic [SIZE_BITS-1:0] chunk;
   logic [SIZE_BITS-1:0] left;
   logic [SIZE_BITS-1:0] left_dec;
   hex_type              hex;
   err_type              err;
   logic                 is_blank;

   // body_start clears state ahead of this byte
   assign ctrl     = body_start ? CTRL_RESET : ctrl_cur;
   assign chunk    = body_start ? '0 : chunk_cur;
   assign left     = body_start ? '0 : left_cur;
   assign left_dec = left - {{(SIZE_BITS-1){1'b0}}, 1'b1};
   assign hex      = hex_decode(data_byte);
   assign is_blank = data_byte inside {CHAR_SP, CHAR_TAB};

   always_comb begin
      ctrl_nxt  = ctrl;
      chunk_nxt = chunk;
      left_nxt  = left;
      result    = '0;
      err       = ERR_NONE;
      case (ctrl.phase)
         PH_LEAD, PH_DIGITS, PH_EXT: begin
            if (ctrl.prev_cr && data_byte == CHAR_LF) begin
               ctrl_nxt.prev_cr = 1'b0;
               if (!ctrl.saw_hex) begin
                  err = ERR_NO_HEX;
               end else begin
                  left_nxt         = chunk;
                  ctrl_nxt.phase   = (chunk == '0) ? PH_TRAILER : PH_DATA;
                  ctrl_nxt.line_ne = 1'b0;
               end
            end else if (ctrl.prev_cr) begin
               // lone CR is non-hex content: digits end, byte is ignored
               ctrl_nxt.phase   = PH_EXT;
               ctrl_nxt.prev_cr = (data_byte == CHAR_CR);
            end else if (data_byte == CHAR_CR) begin
               ctrl_nxt.prev_cr = 1'b1;
            end else if (ctrl.phase != PH_EXT && !(ctrl.phase == PH_LEAD && is_blank)) begin
               if (!hex.ok) begin
                  ctrl_nxt.phase = PH_EXT;
               end else if (chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
                  err = ERR_OVERFLOW;
               end else begin
                  chunk_nxt        = {chunk[SIZE_BITS-5:0], hex.value};
                  ctrl_nxt.saw_hex = 1'b1;
                  ctrl_nxt.phase   = PH_DIGITS;
               end
            end
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = data_byte;
            left_nxt             = left_dec;
            if (left_dec == '0) begin
               ctrl_nxt.phase = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            if (data_byte == CHAR_CR) begin
               ctrl_nxt.phase = PH_DATA_LF;
            end else begin
               err = ERR_CRLF;
            end
         end
         PH_DATA_LF: begin
            if (data_byte == CHAR_LF) begin
               ctrl_nxt.phase   = PH_LEAD;
               chunk_nxt        = '0;
               ctrl_nxt.saw_hex = 1'b0;
               ctrl_nxt.prev_cr = 1'b0;
            end else begin
               err = ERR_CRLF;
            end
         end
         PH_TRAILER: begin
            if (ctrl.prev_cr && data_byte == CHAR_LF) begin
               ctrl_nxt.prev_cr = 1'b0;
               ctrl_nxt.line_ne = 1'b0;
               if (!ctrl.line_ne) begin
                  result.body_done = 1'b1;
                  ctrl_nxt.phase   = PH_DONE;
               end
            end else begin
               ctrl_nxt.prev_cr = (data_byte == CHAR_CR);
               ctrl_nxt.line_ne = ctrl.line_ne | ctrl.prev_cr | (data_byte != CHAR_CR);
            end
         end
         default: begin
            // done, error and unused codes ignore the byte
         end
      endcase
      if (err != ERR_NONE) begin
         ctrl_nxt.phase = PH_ERROR;
      end
      result.error_flag = (err != ERR_NONE);
      result.error_code = err;
   end

endmodule

FILE: rtl/http_chunked_body_decoder_core.sv
// Top level of the HTTP/1.1 chunked transfer body decoder.
//
// Takes one body byte per item and returns exactly one result item per byte:
// payload bytes pass through with payload_valid set, body_done marks the LF
// that closes the final empty trailer line, and error_flag/error_code mark
// the byte that puts the decoder into error (1 no hex digit in a size line,
// 2 missing CR LF after chunk data, 3 chunk size wider than SIZE_BITS).
// After the end or an error every byte yields an all-zero result until an
// item arrives with body_start set, which clears the decoder before that
// byte is decoded. Throughput is one item per clock while rsp_stall does
// not hold a result. An item is held in the input register; its result is
// loaded into the result register when the item advances and offered from
// then on. The rate is set by the state update of phase and the
// SIZE_BITS-wide size and remaining-length counters, which is closed between
// the input register and the result register. A result waiting on rsp_stall
// holds an item in the input register and raises req_stall; an empty input
// register still takes the next byte.
module http_chunked_body_decoder_core
   import chbd_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_body_start,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_payload_valid,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_body_done,
   output logic       rsp_error_flag,
   output logic [1:0] rsp_error_code
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_data_ff, in_data_in;
   logic       in_start_ff, in_start_in;

   // result register
   logic       out_vld_ff, out_vld_in;
   result_type out_res_ff, out_res_in;

   // decoder state
   ctrl_type             ctrl_ff, ctrl_in;
   logic [SIZE_BITS-1:0] chunk_ff, chunk_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;

   // step outputs
   ctrl_type             step_ctrl;
   logic [SIZE_BITS-1:0] step_chunk;
   logic [SIZE_BITS-1:0] step_left;
   result_type           step_res;

   logic advance;
   logic req_accept;

   chbd_step #(
      .SIZE_BITS(SIZE_BITS)
   ) u_step (
      .data_byte (in_data_ff),
      .body_start(in_start_ff),
      .ctrl_cur  (ctrl_ff),
      .chunk_cur (chunk_ff),
      .left_cur  (left_ff),
      .ctrl_nxt  (step_ctrl),
      .chunk_nxt (step_chunk),
      .left_nxt  (step_left),
      .result    (step_res)
   );

   // Item moves from input register into result register when the result
   // slot is empty or is being taken this cycle; state commits on the move.
   assign advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_vld_in   = in_vld_ff;
      in_data_in  = in_data_ff;
      in_start_in = in_start_ff;
      if (advance) begin
         in_vld_in = 1'b0;
      end
      if (req_accept) begin
         in_vld_in   = 1'b1;
         in_data_in  = req_data_byte;
         in_start_in = req_body_start;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff && rsp_stall;
      out_res_in = out_res_ff;
      ctrl_in    = ctrl_ff;
      chunk_in   = chunk_ff;
      left_in    = left_ff;
      if (advance) begin
         out_vld_in = 1'b1;
         out_res_in = step_res;
         ctrl_in    = step_ctrl;
         chunk_in   = step_chunk;
         left_in    = step_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         ctrl_ff    <= CTRL_RESET;
         chunk_ff   <= '0;
         left_ff    <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         ctrl_ff    <= ctrl_in;
         chunk_ff   <= chunk_in;
         left_ff    <= left_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      in_start_ff <= in_start_in;
      out_res_ff  <= out_res_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_payload_valid = out_res_ff.payload_valid;
   assign rsp_payload_byte  = out_res_ff.payload_byte;
   assign rsp_body_done     = out_res_ff.body_done;
   assign rsp_error_flag    = out_res_ff.error_flag;
   assign rsp_error_code    = out_res_ff.error_code;

endmodule

FILE: rtl/chbd_checker.sv
// Port-level assertions for the chunked body decoder, bound to the top level.
module chbd_checker
   import chbd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_payload_valid,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_body_done,
   input logic       rsp_error_flag,
   input logic [1:0] rsp_error_code
);

   // an empty result slot never backs up the input
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall raised with result slot empty");

   // non-payload results carry a zero byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'd0)
      else $error("payload byte nonzero without payload_valid");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_flag == (rsp_error_code != ERR_NONE))
      else $error("error_flag and error_code disagree");

   // a byte is payload, end marker or error, never two of them
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_payload_valid, rsp_body_done, rsp_error_flag}) <= 1)
      else $error("result marks more than one kind");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_valid)
         && $stable(rsp_payload_byte) && $stable(rsp_body_done)
         && $stable(rsp_error_flag) && $stable(rsp_error_code))
      else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder_core chbd_checker u_chbd_checker (.*);
